// ===== rtl/hrv_pkg.sv =====
// Package for the height map row validator: parse phases, error codes,
// character constants and the result type. No dependencies.
package hrv_pkg;

   typedef enum logic [3:0] {
      PH_START   = 4'd0,
      PH_SIGN    = 4'd1,
      PH_DIGITS  = 4'd2,
      PH_PTSPACE = 4'd3,
      PH_COMMA   = 4'd4,
      PH_ZERO    = 4'd5,
      PH_HEX     = 4'd6,
      PH_CSPACE  = 4'd7,
      PH_REST    = 4'd8
   } phase_type;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_POINT      = 3'd1;
   localparam logic [2:0] ERR_END_POINT  = 3'd2;
   localparam logic [2:0] ERR_CLR_PREFIX = 3'd3;
   localparam logic [2:0] ERR_CLR_SYNTAX = 3'd4;
   localparam logic [2:0] ERR_CLR_SIZE   = 3'd5;
   localparam logic [2:0] ERR_CLR_END    = 3'd6;
   localparam logic [2:0] ERR_ROW_LEN    = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPF   = 8'h46;
   localparam logic [7:0] CH_X     = 8'h78;

   localparam logic [2:0] MAX_HEX  = 3'd6;
   localparam logic [2:0] HEX_SAT  = 3'd7;

   typedef struct packed {
      logic [2:0]  error_code;
      logic        row_done;
      logic [15:0] row_points;
      logic [15:0] row_width;
      logic        file_ok;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = is_digit(c) || ((c >= CH_UPA) && (c <= CH_UPF));
   endfunction

endpackage

// ===== rtl/hrv_req_if.sv =====
// Request channel of the row validator: valid/ready plus one character.
// No dependencies.
interface hrv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       row_end;

   modport source(output valid, output ch, output row_end, input ready);
   modport sink(input valid, input ch, input row_end, output ready);
endinterface

// ===== rtl/hrv_rsp_if.sv =====
// Response channel of the row validator: valid/ready plus result fields.
// No dependencies.
interface hrv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  error_code;
   logic        row_done;
   logic [15:0] row_points;
   logic [15:0] row_width;
   logic        file_ok;

   modport source(output valid, output error_code, output row_done, output row_points,
                  output row_width, output file_ok, input ready);
   modport sink(input valid, input error_code, input row_done, input row_points,
                input row_width, input file_ok, output ready);
endinterface

// ===== rtl/hrv_parser.sv =====
// Parse state machine: holds the row/file state and computes one step per
// enabled cycle. Depends on hrv_pkg.
module hrv_parser #(
   parameter int COUNT_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      ch,
   input  logic            row_end,
   input  logic [15:0]     rows_expected,
   output hrv_pkg::rsp_type result
);
   import hrv_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   phase_type             phase_ff, phase_in;
   logic [2:0]            hex_ff, hex_in;
   logic [COUNT_BITS-1:0] points_ff, points_in;
   logic [COUNT_BITS-1:0] width_ff, width_in;
   logic [COUNT_BITS-1:0] rows_ff, rows_in;
   logic [2:0]            err_ff, err_in;

   logic [7:0]            c;
   logic                  eol;
   logic                  active;
   logic                  add_pt;
   logic                  close_req;
   logic                  done;
   logic [COUNT_BITS-1:0] width_close;
   logic [31:0]           shown_wide;
   logic [31:0]           width_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         hex_ff    <= '0;
         points_ff <= '0;
         width_ff  <= '0;
         rows_ff   <= '0;
         err_ff    <= ERR_NONE;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         hex_ff    <= hex_in;
         points_ff <= points_in;
         width_ff  <= width_in;
         rows_ff   <= rows_in;
         err_ff    <= err_in;
      end
   end

   always_comb begin
      c      = row_end ? CH_NUL : ch;
      eol    = (c == CH_NUL) || (c == CH_LF);
      active = (err_ff == ERR_NONE) && (32'(rows_ff) < 32'(rows_expected));

      phase_in    = phase_ff;
      hex_in      = hex_ff;
      points_in   = points_ff;
      width_in    = width_ff;
      rows_in     = rows_ff;
      err_in      = err_ff;
      add_pt      = 1'b0;
      close_req   = 1'b0;
      done        = 1'b0;
      width_close = (width_ff == '0) ? points_ff : width_ff;

      if (active) begin
         case (phase_ff)
            PH_START: begin
               if (c == CH_SPACE) begin
               end else if (eol) begin
                  close_req = 1'b1;
               end else if (c == CH_MINUS) begin
                  phase_in = PH_SIGN;
               end else if (is_digit(c)) begin
                  add_pt = 1'b1;
               end else begin
                  err_in = ERR_POINT;
               end
            end
            PH_SIGN: begin
               if (is_digit(c)) begin
                  add_pt = 1'b1;
               end else begin
                  err_in = ERR_POINT;
               end
            end
            PH_DIGITS, PH_PTSPACE: begin
               if (is_digit(c)) begin
                  add_pt = (phase_ff == PH_PTSPACE);
               end else if (c == CH_SPACE) begin
                  phase_in = PH_PTSPACE;
               end else if (eol) begin
                  close_req = 1'b1;
               end else if (c == CH_COMMA) begin
                  phase_in = PH_COMMA;
               end else if (c == CH_MINUS) begin
                  phase_in = PH_SIGN;
               end else begin
                  err_in = ERR_END_POINT;
               end
            end
            PH_COMMA: begin
               if (c == CH_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  err_in = ERR_CLR_PREFIX;
               end
            end
            PH_ZERO: begin
               if (c == CH_X) begin
                  phase_in = PH_HEX;
                  hex_in   = '0;
               end else begin
                  err_in = ERR_CLR_PREFIX;
               end
            end
            PH_HEX: begin
               if (eol || (c == CH_SPACE)) begin
                  if ((hex_ff == '0) || (hex_ff > MAX_HEX)) begin
                     err_in = ERR_CLR_SIZE;
                  end else if (c == CH_SPACE) begin
                     phase_in = PH_CSPACE;
                  end else begin
                     close_req = 1'b1;
                  end
               end else if (is_hex(c)) begin
                  if (hex_ff < HEX_SAT) begin
                     hex_in = hex_ff + 3'd1;
                  end
               end else begin
                  err_in = ERR_CLR_SYNTAX;
               end
            end
            PH_CSPACE: begin
               if (c == CH_SPACE) begin
               end else if (eol) begin
                  close_req = 1'b1;
               end else if (is_digit(c)) begin
                  add_pt = 1'b1;
               end else begin
                  err_in = ERR_CLR_END;
               end
            end
            default: begin
               if (row_end) begin
                  phase_in = PH_START;
               end
            end
         endcase
      end

      if (add_pt) begin
         if (points_ff != CNT_MAX) begin
            points_in = points_ff + CNT_ONE;
         end
         phase_in = PH_DIGITS;
      end

      if (close_req) begin
         width_in = width_close;
         if ((points_ff != width_close) || (points_ff == '0)) begin
            err_in = ERR_ROW_LEN;
         end else begin
            done = 1'b1;
            if (rows_ff != CNT_MAX) begin
               rows_in = rows_ff + CNT_ONE;
            end
            points_in = '0;
            hex_in    = '0;
            phase_in  = row_end ? PH_START : PH_REST;
         end
      end

      shown_wide = done ? 32'(points_ff) : 32'(points_in);
      width_wide = 32'(width_in);

      result.error_code = err_in;
      result.row_done   = done;
      result.row_points = shown_wide[15:0];
      result.row_width  = width_wide[15:0];
      result.file_ok    = (err_in == ERR_NONE) && (32'(rows_in) >= 32'(rows_expected));
   end

   // sticky error
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ERR_NONE) |=> (err_ff == $past(err_ff)))
      else $error("error code changed after it was set");

   a_width_fixed: assert property (@(posedge clock) disable iff (reset)
      (width_ff != '0) |=> (width_ff == $past(width_ff)))
      else $error("row width changed after first row");

   a_points_mono: assert property (@(posedge clock) disable iff (reset)
      (points_ff != '0) |=> ((points_ff >= $past(points_ff)) || (points_ff == '0)))
      else $error("point count moved backward without row close");

   a_rows_no_err: assert property (@(posedge clock) disable iff (reset)
      (rows_ff != $past(rows_ff)) |-> (err_ff == ERR_NONE))
      else $error("row counted together with an error");

endmodule

// ===== rtl/heightmap_row_validator_unit.sv =====
// Height map row validator: checks one character per request against the
// row/point/colour syntax and reports sticky error and row status per request.
//
// Each request yields exactly one response. The unit takes one request per
// clock unless a stalled sink holds it: a request is registered in the input
// register, then the parse step updates the row state and loads the response
// register in the same cycle. A full response register with a stalled sink
// holds the input side only once the input register is also occupied. Point
// and row counters saturate at COUNT_BITS bits. rows_expected (csr_wr_data)
// must be written only while idle (not enforced by the unit); it resets to 1.
module heightmap_row_validator_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   hrv_req_if.sink     req_if,
   hrv_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import hrv_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_ch_ff;
   logic        in_end_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;
   logic [15:0] rows_exp_ff;

   logic        req_accept;
   logic        step_fire;
   rsp_type     step_result;

   assign step_fire    = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || step_fire;
   assign req_accept   = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = step_fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_exp_ff  <= 16'd1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rows_exp_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ch_ff  <= req_if.ch;
         in_end_ff <= req_if.row_end;
      end
      if (step_fire) begin
         rsp_data_ff <= step_result;
      end
   end

   hrv_parser #(
      .COUNT_BITS(COUNT_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_fire),
      .ch            (in_ch_ff),
      .row_end       (in_end_ff),
      .rows_expected (rows_exp_ff),
      .result        (step_result)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.error_code = rsp_data_ff.error_code;
   assign rsp_if.row_done   = rsp_data_ff.row_done;
   assign rsp_if.row_points = rsp_data_ff.row_points;
   assign rsp_if.row_width  = rsp_data_ff.row_width;
   assign rsp_if.file_ok    = rsp_data_ff.file_ok;

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.row_done) |-> (rsp_data_ff.error_code == ERR_NONE))
      else $error("row closed while an error is reported");

   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.file_ok) |-> (rsp_data_ff.error_code == ERR_NONE))
      else $error("file ok while an error is reported");

   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_fire) |=> in_valid_ff)
      else $error("buffered request dropped");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heightmap_row_validator_unit: rows of height map text
// go in one byte per request, a scoreboard class predicts every response.
// Depends on hrv_pkg, hrv_req_if, hrv_rsp_if and the unit itself.
module testbench;
   import hrv_pkg::*;

   localparam int ROW_PTS = 4;

   class hrv_row_checker;
      logic [15:0] rows_limit;
      phase_type   phase;
      logic [2:0]  hex_cnt;
      logic [15:0] pts;
      logic [15:0] width;
      logic [15:0] rows_done;
      logic [2:0]  err;
      rsp_type     pending_rsp[$];
      int          mismatches;

      function new();
         rows_limit = 16'd1;
         phase      = PH_START;
         hex_cnt    = 3'd0;
         pts        = 16'd0;
         width      = 16'd0;
         rows_done  = 16'd0;
         err        = ERR_NONE;
         mismatches = 0;
      endfunction

      function bit digit(logic [7:0] c);
         return c inside {[CH_ZERO:CH_NINE]};
      endfunction

      function void count_point();
         if (pts != 16'hFFFF) pts++;
         phase = PH_DIGITS;
      endfunction

      function bit end_row(bit marker);
         if (width == 16'd0) width = pts;
         if (pts != width || pts == 16'd0) begin
            err = ERR_ROW_LEN;
            return 1'b0;
         end
         if (rows_done != 16'hFFFF) rows_done++;
         pts     = 16'd0;
         hex_cnt = 3'd0;
         phase   = marker ? PH_START : PH_REST;
         return 1'b1;
      endfunction

      // one accepted request -> one predicted response
      function void take_char(logic [7:0] c, logic e);
         logic [7:0]  cc;
         bit          eol;
         bit          done;
         logic [15:0] shown;
         rsp_type     r;
         cc    = e ? CH_NUL : c;
         eol   = (cc == CH_NUL) || (cc == CH_LF);
         done  = 1'b0;
         shown = pts;
         if (err == ERR_NONE && rows_done < rows_limit) begin
            case (phase)
               PH_START: begin
                  if (cc != CH_SPACE) begin
                     if (eol) done = end_row(e);
                     else if (cc == CH_MINUS) phase = PH_SIGN;
                     else if (digit(cc)) count_point();
                     else err = ERR_POINT;
                  end
               end
               PH_SIGN: begin
                  if (digit(cc)) count_point();
                  else err = ERR_POINT;
               end
               PH_DIGITS, PH_PTSPACE: begin
                  if (digit(cc)) begin
                     if (phase == PH_PTSPACE) count_point();
                  end else if (cc == CH_SPACE) phase = PH_PTSPACE;
                  else if (eol) done = end_row(e);
                  else if (cc == CH_COMMA) phase = PH_COMMA;
                  else if (cc == CH_MINUS) phase = PH_SIGN;
                  else err = ERR_END_POINT;
               end
               PH_COMMA: begin
                  if (cc == CH_ZERO) phase = PH_ZERO;
                  else err = ERR_CLR_PREFIX;
               end
               PH_ZERO: begin
                  if (cc == CH_X) begin
                     phase   = PH_HEX;
                     hex_cnt = 3'd0;
                  end else err = ERR_CLR_PREFIX;
               end
               PH_HEX: begin
                  if (eol || cc == CH_SPACE) begin
                     if (hex_cnt == 3'd0 || hex_cnt > MAX_HEX) err = ERR_CLR_SIZE;
                     else if (cc == CH_SPACE) phase = PH_CSPACE;
                     else done = end_row(e);
                  end else if (digit(cc) || cc inside {[CH_UPA:CH_UPF]}) begin
                     if (hex_cnt != HEX_SAT) hex_cnt++;
                  end else err = ERR_CLR_SYNTAX;
               end
               PH_CSPACE: begin
                  if (cc != CH_SPACE) begin
                     if (eol) done = end_row(e);
                     else if (digit(cc)) count_point();
                     else err = ERR_CLR_END;
                  end
               end
               default: begin
                  if (e) phase = PH_START;
               end
            endcase
            if (!done) shown = pts;
         end
         r.error_code = err;
         r.row_done   = done;
         r.row_points = shown;
         r.row_width  = width;
         r.file_ok    = (err == ERR_NONE) && (rows_done >= rows_limit);
         pending_rsp.push_back(r);
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: exp err=%0d done=%0b pts=%0d width=%0d ok=%0b", what,
                     want.error_code, want.row_done, want.row_points, want.row_width,
                     want.file_ok, "  got err=%0d done=%0b pts=%0d width=%0d ok=%0b",
                     got.error_code, got.row_done, got.row_points, got.row_width,
                     got.file_ok);
      endfunction

      function void match_rsp(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            flag("response with no request", '0, got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.error_code !== want.error_code || got.row_done !== want.row_done ||
             got.row_points !== want.row_points || got.row_width !== want.row_width ||
             got.file_ok !== want.file_ok)
            flag("response mismatch", want, got);
      endfunction
   endclass

   bit          clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   bit          steady;
   int          chars_sent;
   int          stage;
   logic [8:0]  line_q[$];
   hrv_row_checker board;

   hrv_req_if req_ch();
   hrv_rsp_if rsp_ch();

   heightmap_row_validator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.take_char(req_ch.ch, req_ch.row_end);
         if (rsp_ch.valid && rsp_ch.ready)
            board.match_rsp({rsp_ch.error_code, rsp_ch.row_done, rsp_ch.row_points,
                             rsp_ch.row_width, rsp_ch.file_ok});
      end
   end

   initial begin
      #20_000_000;
      $display("heightmap_row_validator_unit verification failed");
      $finish;
   end

   function automatic void push_ch(logic [7:0] c);
      line_q.push_back({1'b0, c});
   endfunction

   function automatic void push_marker();
      line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_ch(s[i]);
   endfunction

   function automatic void push_spaces(int lo, int hi);
      repeat ($urandom_range(lo, hi)) push_ch(CH_SPACE);
   endfunction

   function automatic void push_digits();
      repeat ($urandom_range(1, 3)) push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void push_hex(int n);
      int v;
      repeat (n) begin
         v = $urandom_range(0, 15);
         push_ch(v < 10 ? CH_ZERO + 8'(v) : CH_UPA + 8'(v - 10));
      end
   endfunction

   // random byte that the given parse phase rejects
   function automatic logic [7:0] bad_char(phase_type ph);
      logic [7:0] c;
      bit         eol;
      bit         dig;
      bit         ok;
      forever begin
         c   = 8'($urandom_range(0, 255));
         eol = (c == CH_NUL) || (c == CH_LF);
         dig = c inside {[CH_ZERO:CH_NINE]};
         case (ph)
            PH_START:  ok = !(dig || eol || c == CH_SPACE || c == CH_MINUS);
            PH_SIGN:   ok = !dig;
            PH_DIGITS: ok = !(dig || eol || c inside {CH_SPACE, CH_COMMA, CH_MINUS});
            PH_COMMA:  ok = (c != CH_ZERO);
            PH_ZERO:   ok = (c != CH_X);
            PH_HEX:    ok = !(dig || eol || c == CH_SPACE || c inside {[CH_UPA:CH_UPF]});
            default:   ok = !(dig || eol || c == CH_SPACE);
         endcase
         if (ok) return c;
      end
   endfunction

   // well-formed row of n points, random spacing, signs, colours and terminator
   function automatic void compose_row(int n);
      bit colour;
      bit sign;
      line_q.delete();
      push_spaces(0, 2);
      colour = 1'b0;
      for (int i = 0; i < n; i++) begin
         sign = ($urandom_range(0, 3) == 0);
         if (i > 0) begin
            if (colour) begin
               push_spaces(1, 2);
               sign = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
               push_spaces(1, 2);
            end else begin
               push_spaces(0, 1);
               sign = 1'b1;
            end
         end
         if (sign) push_ch(CH_MINUS);
         push_digits();
         colour = ($urandom_range(0, 2) == 0);
         if (colour) begin
            push_spaces(0, 1);
            push_text(",0x");
            push_hex($urandom_range(1, 6));
         end
      end
      push_spaces(0, 2);
      if ($urandom_range(0, 1)) begin
         push_marker();
      end else begin
         push_ch($urandom_range(0, 1) ? CH_LF : CH_NUL);
         repeat ($urandom_range(0, 4)) push_ch(8'($urandom_range(0, 255)));
         push_marker();
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic e);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.ch      <= c;
      req_ch.row_end <= e;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i][7:0], line_q[i][8]);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_rows(input logic [15:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      board.rows_limit = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // the error is sticky until reset, so exactly one kind closes the run
   task automatic end_with_error();
      logic [2:0] goal;
      goal = 3'($urandom_range(1, 7));
      line_q.delete();
      case (goal)
         ERR_POINT: begin
            if ($urandom_range(0, 1)) begin
               push_ch(bad_char(PH_START));
            end else begin
               push_text("3 -");
               push_ch(bad_char(PH_SIGN));
            end
         end
         ERR_END_POINT: begin
            push_digits();
            push_ch(bad_char(PH_DIGITS));
         end
         ERR_CLR_PREFIX: begin
            push_text("3,");
            if ($urandom_range(0, 1)) begin
               push_ch(bad_char(PH_COMMA));
            end else begin
               push_ch(CH_ZERO);
               push_ch(bad_char(PH_ZERO));
            end
         end
         ERR_CLR_SYNTAX: begin
            push_text("3,0x");
            push_hex($urandom_range(0, 3));
            push_ch(bad_char(PH_HEX));
         end
         ERR_CLR_SIZE: begin
            push_text("3,0x");
            push_hex($urandom_range(0, 1) ? 0 : $urandom_range(7, 9));
            case ($urandom_range(0, 2))
               0: push_ch(CH_SPACE);
               1: push_ch(CH_LF);
               default: push_marker();
            endcase
         end
         ERR_CLR_END: begin
            push_text("3,0x");
            push_hex($urandom_range(1, 6));
            push_spaces(1, 2);
            push_ch($urandom_range(0, 1) ? CH_MINUS : bad_char(PH_CSPACE));
         end
         default: begin
            if ($urandom_range(0, 1)) begin
               compose_row(ROW_PTS + $urandom_range(1, 3));
            end else begin
               compose_row($urandom_range(0, ROW_PTS - 1));
            end
         end
      endcase
      send_line();
      repeat (40) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.ch      = 8'd0;
      req_ch.row_end = 1'b0;
      rsp_ch.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 16'd0;
      steady         = 1'b0;
      chars_sent     = 0;
      stage          = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // first row fixes the width at four; reset limit of one freezes the rest
      line_q.delete();
      push_text("-9 0,0xFFFFFF  12-3 ,0xA");
      push_marker();
      push_ch(CH_NUL);
      push_ch(8'hFF);
      push_ch(CH_LF);
      push_marker();
      send_line();
      write_rows(16'hFFFF);

      while (chars_sent < 2000) begin
         if (stage == 0 && chars_sent >= 400) begin
            write_rows(board.rows_done + 16'd8);
            stage = 1;
         end else if (stage == 1 && chars_sent >= 700) begin
            write_rows(16'd1);
            stage = 2;
         end else if (stage == 2 && chars_sent >= 900) begin
            write_rows(16'hFFFF);
            steady = 1'b1;
            stage  = 3;
         end else if (stage == 3 && chars_sent >= 1400) begin
            steady = 1'b0;
            write_rows(board.rows_done + 16'($urandom_range(1, 20)));
            stage = 4;
         end else if (stage == 4 && chars_sent >= 1800) begin
            write_rows(16'hFFFF);
            stage = 5;
         end
         compose_row(ROW_PTS);
         send_line();
      end

      end_with_error();
      settle();
      if (board.mismatches == 0 && board.pending_rsp.size() == 0)
         $display("heightmap_row_validator_unit verification clean");
      else
         $display("heightmap_row_validator_unit verification failed");
      $finish;
   end
endmodule
